[hw/rtl/bds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Baud divider search package
// Field widths, fixed arithmetic constants and the sequencer state type used
// by the baud divider search block.
// ----------------------------------------------------------------------------
package bds_pkg;

  // Field and register widths
  localparam int unsigned BAUD_W      = 22;
  localparam int unsigned CLK_W       = 32;
  localparam int unsigned SCALE_OUT_W = 8;
  localparam int unsigned STEP_OUT_W  = 16;

  // Step is expressed in units of 2^-17
  localparam int unsigned FRAC_BITS = 17;

  // Reference clock after reset
  localparam logic [CLK_W-1:0] CLK_RESET = 32'd27000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_DIV1,
    ST_CHK,
    ST_MUL2,
    ST_DIV2,
    ST_ERR,
    ST_CMP,
    ST_FINISH
  } bds_state_e;

endpackage

[hw/rtl/baud_divider_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Baud divider search
// Finds the prescaler and fractional step that best approach a requested baud
// rate from the configured reference clock, using one shared divider.
// ----------------------------------------------------------------------------
// Flow: with a zero clock register no division runs; otherwise each divisor
//   scale + 1 up to SCALE_LIMIT takes two DVD_W-bit divisions (DVD_W = 47 at
//   the default parameters). The search stops early at the first step above
//   STEP_LIMIT.
// Throughput: one item at a time; the single restoring divider, one quotient
//   bit per cycle, serves both divisions. A finished result waits in the output
//   register while the next item is taken.
// Reset: asynchronous, active low; the clock register returns to 27 MHz and
//   no result is pending.
module baud_divider_search #(
  parameter int unsigned SCALE_LIMIT = 255,
  parameter int unsigned STEP_LIMIT  = 65535
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bds_pkg::BAUD_W-1:0]          target_baud_i,
  // Result items
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bds_pkg::SCALE_OUT_W-1:0]     best_scale_o,
  output logic [bds_pkg::STEP_OUT_W-1:0]      best_step_o,
  // Reference clock register write
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bds_pkg::CLK_W-1:0]           cfg_data_i
);

  // Prescaler counter and divisor (scale + 1) widths
  localparam int unsigned SCI_W  = $clog2(SCALE_LIMIT);
  localparam int unsigned SC_W   = $clog2(SCALE_LIMIT + 1);
  // Step width
  localparam int unsigned ST_W   = $clog2(STEP_LIMIT + 1);
  // First dividend: baud * (scale + 1) * 2^17
  localparam int unsigned BS_W   = bds_pkg::BAUD_W + SC_W;
  localparam int unsigned N1_W   = BS_W + bds_pkg::FRAC_BITS;
  // Second dividend: (clk * step + (scale + 1) * 2^16) >> 17
  localparam int unsigned PROD_W = bds_pkg::CLK_W + ST_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned Y_W    = SUM_W - bds_pkg::FRAC_BITS;
  // Shared divider dividend width and iteration counter
  localparam int unsigned DVD_W  = (N1_W > Y_W) ? N1_W : Y_W;
  localparam int unsigned CNT_W  = $clog2(DVD_W + 1);
  localparam int unsigned DVS_W  = bds_pkg::CLK_W;

  bds_pkg::bds_state_e state_q, state_d;

  logic [bds_pkg::CLK_W-1:0]  clk_hz_q;
  logic [bds_pkg::BAUD_W-1:0] baud_q;
  logic [SCI_W-1:0]           scale_q;
  logic [SC_W-1:0]            sp1;

  // Shared restoring divider: remainder, dividend/quotient shifter, divisor
  logic [DVS_W-1:0]           div_rem_q;
  logic [DVD_W-1:0]           div_num_q;
  logic [DVS_W-1:0]           div_dvs_q;
  logic [CNT_W-1:0]           div_cnt_q;
  logic [DVS_W:0]             div_trial;
  logic [DVS_W+1:0]           div_diff;
  logic                       div_qbit;
  logic [DVS_W-1:0]           div_rem_nxt;

  logic [ST_W-1:0]            step_q;
  logic [PROD_W-1:0]          prod_q;
  logic [DVD_W-1:0]           err_q;
  logic [DVD_W-1:0]           bound_q;
  logic [SCI_W-1:0]           pick_scale_q;
  logic [ST_W-1:0]            pick_step_q;

  logic                       out_valid_q;
  logic [bds_pkg::SCALE_OUT_W-1:0] out_scale_q;
  logic [bds_pkg::STEP_OUT_W-1:0]  out_step_q;

  logic [BS_W-1:0]            bs_mul;
  logic [N1_W-1:0]            n1;
  logic [SUM_W-1:0]           sum2;
  logic [Y_W-1:0]             y2;
  logic [DVD_W-1:0]           baud_ext;
  logic                       step_over;
  logic                       last_scale;
  logic                       take_in;
  logic                       out_load;
  logic [SCI_W+bds_pkg::SCALE_OUT_W-1:0] scale_wide;
  logic [ST_W+bds_pkg::STEP_OUT_W-1:0]   step_wide;

  // Handshake: take an item only while idle and no register write is offered,
  // so an item never sees the clock register change under it; the output
  // register is separate
  assign in_stall_o  = (state_q != bds_pkg::ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == bds_pkg::ST_IDLE);
  assign take_in     = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == bds_pkg::ST_FINISH) && (!out_valid_q || !out_stall_i);

  assign sp1        = SC_W'(scale_q) + SC_W'(1);
  assign last_scale = (scale_q == SCI_W'(SCALE_LIMIT - 1));
  assign baud_ext   = DVD_W'(baud_q);

  // First dividend: baud * (scale + 1), then shift up by the fraction bits
  assign bs_mul = BS_W'(baud_q) * BS_W'(sp1);
  assign n1     = {bs_mul, {bds_pkg::FRAC_BITS{1'b0}}};

  // Second dividend: add half of (scale + 1) * 2^17 to round half up, then
  // drop the 2^17 factor so the divisor is just scale + 1
  assign sum2 = SUM_W'(prod_q) + (SUM_W'(sp1) << (bds_pkg::FRAC_BITS - 1));
  assign y2   = sum2[SUM_W-1:bds_pkg::FRAC_BITS];

  // Step from the first division overshoots the limit: end the search
  assign step_over = (div_num_q > DVD_W'(STEP_LIMIT));

  // One restoring division step: bring down the next dividend bit, try the
  // subtraction, keep it when it does not borrow
  assign div_trial   = {div_rem_q, div_num_q[DVD_W-1]};
  assign div_diff    = {1'b0, div_trial} - {2'b00, div_dvs_q};
  assign div_qbit    = !div_diff[DVS_W+1];
  assign div_rem_nxt = div_qbit ? div_diff[DVS_W-1:0] : div_trial[DVS_W-1:0];

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bds_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bds_pkg::ST_IDLE: begin
        if (take_in) begin
          // Zero clock: no division, report the empty pair
          state_d = (clk_hz_q == '0) ? bds_pkg::ST_FINISH : bds_pkg::ST_MUL1;
        end
      end
      bds_pkg::ST_MUL1: begin
        state_d = bds_pkg::ST_DIV1;
      end
      bds_pkg::ST_DIV1: begin
        if (div_cnt_q == CNT_W'(1)) begin
          state_d = bds_pkg::ST_CHK;
        end
      end
      bds_pkg::ST_CHK: begin
        state_d = step_over ? bds_pkg::ST_FINISH : bds_pkg::ST_MUL2;
      end
      bds_pkg::ST_MUL2: begin
        state_d = bds_pkg::ST_DIV2;
      end
      bds_pkg::ST_DIV2: begin
        if (div_cnt_q == CNT_W'(1)) begin
          state_d = bds_pkg::ST_ERR;
        end
      end
      bds_pkg::ST_ERR: begin
        state_d = bds_pkg::ST_CMP;
      end
      bds_pkg::ST_CMP: begin
        state_d = last_scale ? bds_pkg::ST_FINISH : bds_pkg::ST_MUL1;
      end
      bds_pkg::ST_FINISH: begin
        if (out_load) begin
          state_d = bds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bds_pkg::ST_IDLE;
      end
    endcase
  end

  // Reference clock register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= bds_pkg::CLK_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      clk_hz_q <= cfg_data_i;
    end
  end

  // Search datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      bds_pkg::ST_IDLE: begin
        if (take_in) begin
          // Start from an error bound equal to the target, empty pair
          baud_q       <= target_baud_i;
          bound_q      <= DVD_W'(target_baud_i);
          scale_q      <= '0;
          pick_scale_q <= '0;
          pick_step_q  <= '0;
        end
      end
      bds_pkg::ST_MUL1: begin
        div_num_q <= DVD_W'(n1);
        div_dvs_q <= clk_hz_q;
        div_rem_q <= '0;
        div_cnt_q <= CNT_W'(DVD_W);
      end
      bds_pkg::ST_DIV1, bds_pkg::ST_DIV2: begin
        div_rem_q <= div_rem_nxt;
        div_num_q <= {div_num_q[DVD_W-2:0], div_qbit};
        div_cnt_q <= div_cnt_q - CNT_W'(1);
      end
      bds_pkg::ST_CHK: begin
        // Hold the step and form clk * step for the achieved rate
        step_q <= div_num_q[ST_W-1:0];
        prod_q <= PROD_W'(clk_hz_q) * PROD_W'(div_num_q[ST_W-1:0]);
      end
      bds_pkg::ST_MUL2: begin
        div_num_q <= DVD_W'(y2);
        div_dvs_q <= DVS_W'(sp1);
        div_rem_q <= '0;
        div_cnt_q <= CNT_W'(DVD_W);
      end
      bds_pkg::ST_ERR: begin
        err_q <= (div_num_q >= baud_ext) ? (div_num_q - baud_ext) : (baud_ext - div_num_q);
      end
      bds_pkg::ST_CMP: begin
        // Strictly smaller error only, so the first best pair stays
        if (err_q < bound_q) begin
          bound_q      <= err_q;
          pick_scale_q <= scale_q;
          pick_step_q  <= step_q;
        end
        if (!last_scale) begin
          scale_q <= scale_q + SCI_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: truncate or widen the picks to the port widths
  assign scale_wide = {{bds_pkg::SCALE_OUT_W{1'b0}}, pick_scale_q};
  assign step_wide  = {{bds_pkg::STEP_OUT_W{1'b0}}, pick_step_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_scale_q <= scale_wide[bds_pkg::SCALE_OUT_W-1:0];
      out_step_q  <= step_wide[bds_pkg::STEP_OUT_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_scale_o = out_scale_q;
  assign best_step_o  = out_step_q;

endmodule

[hw/rtl/bds_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Baud divider search port checker
// Watches the top-level ports of the baud divider search block over time.
// ----------------------------------------------------------------------------
module bds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  best_scale_o,
  input logic [15:0] best_step_o,
  input logic        cfg_ready_o
);

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(best_scale_o)
                                   && $stable(best_step_o))
    else $error("result item changed while stalled");

  // After an item is taken the block is busy: no new item, no register write
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_stall_o && !cfg_ready_o)
    else $error("block not busy after taking an item");

  // A zero step means no match, which always comes with scale zero
  a_no_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (best_step_o == 16'd0) |-> best_scale_o == 8'd0)
    else $error("zero step reported with non-zero scale");

  // No result appears in the cycle right after an item is taken while no earlier result is stalled
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && (!out_valid_o || !out_stall_i) |=> !out_valid_o)
    else $error("result item appeared too early");

endmodule

bind baud_divider_search bds_checker u_bds_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .best_scale_o  (best_scale_o),
  .best_step_o   (best_step_o),
  .cfg_ready_o   (cfg_ready_o)
);
